// ----- hdl/htd_pkg.sv -----
package htd_pkg;

  localparam int unsigned NODE_COUNT = 255;
  localparam int unsigned NODE_W     = 8;
  localparam int unsigned SYM_W      = 7;
  localparam int unsigned COUNT_W    = 24;
  localparam int unsigned ENTRY_W    = 2 * NODE_W + SYM_W;
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned BITCNT_W   = $clog2(BYTE_W + 1);

  localparam logic CMD_LOAD   = 1'b0;
  localparam logic CMD_DECODE = 1'b1;

  localparam logic CFG_ROOT_NODE    = 1'b0;
  localparam logic CFG_SYMBOL_COUNT = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_CHECK,
    ST_FLUSH
  } htd_state_t;

  typedef struct packed {
    logic [NODE_W-1:0] left;
    logic [NODE_W-1:0] right;
    logic [SYM_W-1:0]  sym;
  } htd_entry_t;

endpackage

// ----- hdl/huffman_tree_decoder_top.sv -----
// Channel | Direction | Handshake              | Payload
// in_     | sink      | in_tvalid / in_tready   | tuser: command; tdata: node load or data byte
// out_    | source    | out_tvalid / out_tready | tdata: symbol; tlast: last_of_byte;
//         |           |                        | tuser: stream_done
// cfg_    | sink      | cfg_we                 | cfg_addr: register, cfg_wdata: value
//
// A load beat is accepted whenever the decoder is idle. A data beat holds off further input
// until its byte is decoded: every bit step is one registered read of the node memory, and
// each leaf costs one extra read of the root.
// A data beat arriving with no symbols left is dropped in its accept cycle.
// rst_n is synchronous; the node memory is not cleared and reads as written.
// A stalled out_ channel holds the walk at the next leaf until the output register drains.
module huffman_tree_decoder_top
  import htd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [7:0] node_index, [15:8] left_child, [23:16] right_child, [30:24] node_symbol,
  // [38:31] data_byte, [39] zero
  input  logic [39:0] in_tdata,
  // [0] command
  input  logic        in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [6:0] symbol, [7] zero
  output logic [7:0]  out_tdata,
  output logic        out_tlast,
  // [0] stream_done
  output logic        out_tuser,
  input  logic        cfg_we,
  input  logic        cfg_addr,
  input  logic [23:0] cfg_wdata
);

  htd_entry_t             mem [NODE_COUNT];

  htd_state_t             st_r, st_nxt;
  logic [NODE_W-1:0]      root_r;
  logic [NODE_W-1:0]      cur_node_r;
  logic [COUNT_W-1:0]     symbols_left_r;
  logic [BYTE_W-1:0]      byte_r;
  logic [BITCNT_W-1:0]    bits_left_r;
  htd_entry_t             rd_q_r;
  logic                   rd_oor_r;
  logic                   pend_valid_r;
  logic [SYM_W-1:0]       pend_sym_r;
  logic                   pend_done_r;
  logic                   out_valid_r;
  logic [SYM_W-1:0]       out_sym_r;
  logic                   out_last_r;
  logic                   out_done_r;

  logic                   in_fire;
  logic                   out_free;
  htd_entry_t             node;
  logic                   leaf;
  logic [NODE_W-1:0]      step_next;
  logic [NODE_W-1:0]      in_idx;
  logic                   rd_en;
  logic [NODE_W-1:0]      rd_addr;
  logic                   do_step;
  logic                   do_leaf;
  logic                   push;
  logic                   push_last;

  assign in_fire   = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;
  assign in_idx    = in_tdata[7:0];
  assign node      = rd_oor_r ? '0 : rd_q_r;
  assign leaf      = (node.sym != '0);
  assign step_next = byte_r[BYTE_W-1] ? node.right : node.left;

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ST_IDLE: begin
        if (in_fire && (in_tuser == CMD_DECODE) && (symbols_left_r != '0)) begin
          st_nxt = ST_WALK;
        end
      end
      ST_WALK: st_nxt = ST_CHECK;
      ST_CHECK: begin
        if (leaf) begin
          if (!pend_valid_r || out_free) begin
            if ((symbols_left_r == COUNT_W'(1)) || (bits_left_r == '0)) begin
              st_nxt = ST_FLUSH;
            end else begin
              st_nxt = ST_WALK;
            end
          end
        end else if (bits_left_r == '0) begin
          st_nxt = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (!pend_valid_r || out_free) begin
          st_nxt = ST_IDLE;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_tready = 1'b0;
    rd_en     = 1'b0;
    rd_addr   = cur_node_r;
    do_step   = 1'b0;
    do_leaf   = 1'b0;
    push      = 1'b0;
    push_last = 1'b0;
    case (st_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        rd_en     = in_fire && (in_tuser == CMD_DECODE);
      end
      ST_WALK: begin
        do_step = 1'b1;
        rd_en   = 1'b1;
        rd_addr = step_next;
      end
      ST_CHECK: begin
        if (leaf) begin
          if (!pend_valid_r || out_free) begin
            do_leaf = 1'b1;
            push    = pend_valid_r;
            rd_en   = 1'b1;
            rd_addr = root_r;
          end
        end else if (bits_left_r != '0) begin
          do_step = 1'b1;
          rd_en   = 1'b1;
          rd_addr = step_next;
        end
      end
      ST_FLUSH: begin
        if (pend_valid_r && out_free) begin
          push      = 1'b1;
          push_last = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // node memory
  always_ff @(posedge clk) begin
    if (in_fire && (in_tuser == CMD_LOAD) && (32'(in_idx) < NODE_COUNT)) begin
      mem[in_idx] <= '{left: in_tdata[15:8], right: in_tdata[23:16], sym: in_tdata[30:24]};
    end
    if (rd_en) begin
      rd_oor_r <= !(32'(rd_addr) < NODE_COUNT);
      if (32'(rd_addr) < NODE_COUNT) begin
        rd_q_r <= mem[rd_addr];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r           <= ST_IDLE;
      root_r         <= '0;
      cur_node_r     <= '0;
      symbols_left_r <= '0;
      bits_left_r    <= '0;
      pend_valid_r   <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (cfg_we) begin
        case (cfg_addr)
          CFG_ROOT_NODE: begin
            root_r     <= cfg_wdata[NODE_W-1:0];
            cur_node_r <= cfg_wdata[NODE_W-1:0];
          end
          CFG_SYMBOL_COUNT: symbols_left_r <= cfg_wdata[COUNT_W-1:0];
          default: ;
        endcase
      end
      if (in_fire && (in_tuser == CMD_DECODE)) begin
        bits_left_r <= BITCNT_W'(BYTE_W);
      end
      if (do_step) begin
        cur_node_r  <= step_next;
        bits_left_r <= bits_left_r - BITCNT_W'(1);
      end
      if (do_leaf) begin
        symbols_left_r <= symbols_left_r - COUNT_W'(1);
        cur_node_r     <= root_r;
        pend_valid_r   <= 1'b1;
      end else if (push) begin
        pend_valid_r <= 1'b0;
      end
      if (push) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && (in_tuser == CMD_DECODE)) begin
      byte_r <= in_tdata[38:31];
    end else if (do_step) begin
      byte_r <= {byte_r[BYTE_W-2:0], 1'b0};
    end
    if (do_leaf) begin
      pend_sym_r  <= node.sym;
      pend_done_r <= (symbols_left_r == COUNT_W'(1));
    end
    if (push) begin
      out_sym_r  <= pend_sym_r;
      out_last_r <= push_last;
      out_done_r <= pend_done_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_sym_r};
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_done_r;

  a_idle_no_pending : assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !pend_valid_r)
    else $error("input ready while a symbol is still pending");

  a_done_is_last : assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser) |-> out_tlast)
    else $error("stream_done beat not marked last");

  a_no_underflow : assert property (@(posedge clk) disable iff (!rst_n)
    do_leaf |-> (symbols_left_r != '0))
    else $error("symbol emitted with no symbols left");

  a_walk_has_bits : assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_WALK) |-> (bits_left_r != '0))
    else $error("tree step with no bits left in the byte");

endmodule
